>>> hdl/ffca_pkg.sv
// Shared types and constants of the first-fit cell allocator.
package ffca_pkg;

  // Payload field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned AMOUNT_W = 8;
  localparam int unsigned EID_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned AID_W    = 16;

  // Configuration port
  localparam int unsigned CFG_W       = 8;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam logic [CFG_W-1:0] CELLS_RESET = 8'd128;
  localparam logic REG_CELLS_IN_USE = 1'b0;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ERASE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DEFRAG = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAIL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL = 2'd2;

  // Datapath operation selected by the controller
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_ALLOC_SCAN,
    CMD_FILL,
    CMD_ERASE_SCAN,
    CMD_DEFRAG_SCAN,
    CMD_TAIL
  } dp_cmd_e;

  typedef struct packed {
    logic    load;
    dp_cmd_e cmd;
  } dp_ctrl_t;

  typedef struct packed {
    logic             ok;
    logic             scan_done;
    logic             found;
    logic             fill_done;
    logic             freed;
    logic             tail_done;
    logic             clear_done;
    logic [AID_W-1:0] id;
  } dp_stat_t;

endpackage

>>> hdl/ffca_if.sv
// Valid/ready channel interfaces for request and result beats.
interface ffca_item_if;
  import ffca_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [AMOUNT_W-1:0] amount;
  logic [EID_W-1:0]    erase_id;

  modport source (output valid, action, amount, erase_id, input ready);
  modport sink   (input valid, action, amount, erase_id, output ready);
endinterface

interface ffca_res_if;
  import ffca_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [AID_W-1:0]    alloc_id;

  modport source (output valid, status, alloc_id, input ready);
  modport sink   (input valid, status, alloc_id, output ready);
endinterface

>>> hdl/ffca_datapath.sv
// Cell store, scan counters and identifier counter of the allocator.
module ffca_datapath #(
  parameter int unsigned MAX_CELLS = 128,
  parameter int unsigned ID_BITS   = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ffca_pkg::dp_ctrl_t        ctrl_i,
  input  logic [ffca_pkg::CFG_W-1:0]    cells_in_use_i,
  input  logic [ffca_pkg::AMOUNT_W-1:0] amount_i,
  input  logic [ffca_pkg::EID_W-1:0]    erase_id_i,
  output ffca_pkg::dp_stat_t        stat_o
);
  import ffca_pkg::*;

  localparam int unsigned AW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_CELLS + 1);
  localparam int unsigned MW    = (CNT_W > AMOUNT_W) ? CNT_W : AMOUNT_W;
  localparam int unsigned XW    = MW + 1;
  localparam int unsigned CMP_W = (ID_BITS > EID_W) ? ID_BITS : EID_W;

  // Cell store
  logic [ID_BITS-1:0] mem_q [MAX_CELLS];
  logic [ID_BITS-1:0] rdata_q;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [ID_BITS-1:0] wdata;
  logic               re;

  // Control registers
  logic [CNT_W-1:0]    cnt_q, m_q, wr_q, fp_q;
  logic [AW-1:0]       addr_q;
  logic                vld_q, found_q, freed_q, ok_q;
  logic [AMOUNT_W-1:0] run_q, left_q, amount_q;
  logic [EID_W-1:0]    eid_q;
  logic [ID_BITS-1:0]  last_id_q;

  logic [CNT_W-1:0]    m_d;
  logic                scanning;
  logic [AMOUNT_W:0]   run_nx;
  logic                hit;
  logic [XW-1:0]       start_x;
  logic                eid_match;

  // Active cell count, limited to the store size
  assign m_d = (MW'(cells_in_use_i) > MW'(MAX_CELLS)) ? CNT_W'(MAX_CELLS)
                                                      : CNT_W'(cells_in_use_i);

  assign scanning = (ctrl_i.cmd == CMD_ALLOC_SCAN) || (ctrl_i.cmd == CMD_ERASE_SCAN) ||
                    (ctrl_i.cmd == CMD_DEFRAG_SCAN);
  assign re = scanning && (cnt_q < m_q);

  // Free-run tracking for first fit
  assign run_nx  = (rdata_q == '0) ? ({1'b0, run_q} + 1'b1) : '0;
  assign hit     = vld_q && !found_q && (run_nx == {1'b0, amount_q});
  assign start_x = XW'(addr_q) + XW'(1) - XW'(amount_q);

  assign eid_match = (CMP_W'(rdata_q) == CMP_W'(eid_q)) && (eid_q != '0);

  // Write port selection
  always_comb begin
    we    = 1'b0;
    waddr = cnt_q[AW-1:0];
    wdata = '0;
    case (ctrl_i.cmd)
      CMD_CLEAR: begin
        we    = (cnt_q != CNT_W'(MAX_CELLS));
        waddr = cnt_q[AW-1:0];
      end
      CMD_FILL: begin
        we    = (left_q != '0);
        waddr = fp_q[AW-1:0];
        wdata = last_id_q;
      end
      CMD_ERASE_SCAN: begin
        we    = vld_q && eid_match;
        waddr = addr_q;
      end
      CMD_DEFRAG_SCAN: begin
        we    = vld_q && (rdata_q != '0);
        waddr = wr_q[AW-1:0];
        wdata = rdata_q;
      end
      CMD_TAIL: begin
        we    = (wr_q < m_q);
        waddr = wr_q[AW-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[cnt_q[AW-1:0]];
    end
  end

  // Item fields
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      amount_q <= amount_i;
      eid_q    <= erase_id_i;
    end
  end

  // Counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      m_q       <= '0;
      wr_q      <= '0;
      fp_q      <= '0;
      addr_q    <= '0;
      vld_q     <= 1'b0;
      found_q   <= 1'b0;
      freed_q   <= 1'b0;
      ok_q      <= 1'b0;
      run_q     <= '0;
      left_q    <= '0;
      last_id_q <= '0;
    end else if (ctrl_i.load) begin
      cnt_q   <= '0;
      m_q     <= m_d;
      wr_q    <= '0;
      vld_q   <= 1'b0;
      found_q <= 1'b0;
      freed_q <= 1'b0;
      run_q   <= '0;
      ok_q    <= (amount_i != '0) && (MW'(amount_i) <= MW'(m_d)) && (last_id_q != '1);
    end else begin
      // read issue and pipeline tag
      if (scanning) begin
        vld_q  <= re;
        addr_q <= cnt_q[AW-1:0];
        if (re) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end else begin
        vld_q <= 1'b0;
      end
      case (ctrl_i.cmd)
        CMD_CLEAR: begin
          if (cnt_q != CNT_W'(MAX_CELLS)) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        CMD_ALLOC_SCAN: begin
          if (vld_q && !found_q) begin
            run_q <= run_nx[AMOUNT_W-1:0];
          end
          if (hit) begin
            found_q   <= 1'b1;
            fp_q      <= CNT_W'(start_x);
            left_q    <= amount_q;
            last_id_q <= last_id_q + 1'b1;
          end
        end
        CMD_FILL: begin
          if (left_q != '0) begin
            fp_q   <= fp_q + 1'b1;
            left_q <= left_q - 1'b1;
          end
        end
        CMD_ERASE_SCAN: begin
          if (vld_q && eid_match) begin
            freed_q <= 1'b1;
          end
        end
        CMD_DEFRAG_SCAN: begin
          if (vld_q && (rdata_q != '0)) begin
            wr_q <= wr_q + 1'b1;
          end
        end
        CMD_TAIL: begin
          if (wr_q < m_q) begin
            wr_q <= wr_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Status back to the controller
  assign stat_o.ok         = ok_q;
  assign stat_o.scan_done  = (cnt_q == m_q) && !vld_q;
  assign stat_o.found      = found_q;
  assign stat_o.fill_done  = (left_q == '0);
  assign stat_o.freed      = freed_q;
  assign stat_o.tail_done  = (wr_q == m_q);
  assign stat_o.clear_done = (cnt_q == CNT_W'(MAX_CELLS));
  assign stat_o.id         = AID_W'(last_id_q);

endmodule

>>> hdl/ffca_ctrl.sv
// Sequencer of the allocator: steps each request through the datapath.
module ffca_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [ffca_pkg::ACTION_W-1:0] in_action_i,
  output logic                          in_ready_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [ffca_pkg::STATUS_W-1:0] out_status_o,
  output logic [ffca_pkg::AID_W-1:0]    out_alloc_id_o,
  output ffca_pkg::dp_ctrl_t            dp_ctrl_o,
  input  ffca_pkg::dp_stat_t            dp_stat_i
);
  import ffca_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ACHECK,
    S_ASCAN,
    S_AFILL,
    S_ERASE,
    S_DEFRAG,
    S_TAIL,
    S_EMIT
  } state_e;

  state_e              state_q;
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q, pend_q;
  logic [AID_W-1:0]    alloc_id_q;
  logic                accept;
  logic                slot_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  // Datapath command follows the state
  always_comb begin
    dp_ctrl_o.load = accept;
    case (state_q)
      S_CLEAR:  dp_ctrl_o.cmd = CMD_CLEAR;
      S_ASCAN:  dp_ctrl_o.cmd = CMD_ALLOC_SCAN;
      S_AFILL:  dp_ctrl_o.cmd = CMD_FILL;
      S_ERASE:  dp_ctrl_o.cmd = CMD_ERASE_SCAN;
      S_DEFRAG: dp_ctrl_o.cmd = CMD_DEFRAG_SCAN;
      S_TAIL:   dp_ctrl_o.cmd = CMD_TAIL;
      default:  dp_ctrl_o.cmd = CMD_NONE;
    endcase
  end

  // State and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      pend_q      <= ST_OK;
      alloc_id_q  <= '0;
    end else begin
      // the emit state reloads the slot itself
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (dp_stat_i.clear_done) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (in_action_i)
              ACT_ALLOC:  state_q <= S_ACHECK;
              ACT_ERASE:  state_q <= S_ERASE;
              ACT_DEFRAG: state_q <= S_DEFRAG;
              default:    state_q <= S_IDLE;
            endcase
          end
        end
        S_ACHECK: begin
          if (dp_stat_i.ok) begin
            state_q <= S_ASCAN;
          end else begin
            pend_q  <= ST_FAIL;
            state_q <= S_EMIT;
          end
        end
        S_ASCAN: begin
          if (dp_stat_i.found) begin
            state_q <= S_AFILL;
          end else if (dp_stat_i.scan_done) begin
            pend_q  <= ST_FAIL;
            state_q <= S_EMIT;
          end
        end
        S_AFILL: begin
          if (dp_stat_i.fill_done) begin
            pend_q  <= ST_OK;
            state_q <= S_EMIT;
          end
        end
        S_ERASE: begin
          if (dp_stat_i.scan_done) begin
            if (dp_stat_i.freed) begin
              state_q <= S_IDLE;
            end else begin
              pend_q  <= ST_ILLEGAL;
              state_q <= S_EMIT;
            end
          end
        end
        S_DEFRAG: begin
          if (dp_stat_i.scan_done) begin
            state_q <= S_TAIL;
          end
        end
        S_TAIL: begin
          if (dp_stat_i.tail_done) begin
            state_q <= S_IDLE;
          end
        end
        S_EMIT: begin
          // wait for a free output slot
          if (slot_free) begin
            out_valid_q <= 1'b1;
            status_q    <= pend_q;
            alloc_id_q  <= (pend_q == ST_OK) ? dp_stat_i.id : '0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = status_q;
  assign out_alloc_id_o = alloc_id_q;

endmodule

>>> hdl/first_fit_cell_allocator_unit.sv
// Top level of the first-fit cell allocator with compaction.
//
// Requests arrive on item_i (valid/ready): allocate a run of amount cells,
// erase every cell of erase_id, or defragment. Results leave on result_o:
// one beat for every allocate, one for an illegal erase, none otherwise.
// The APB port holds cells_in_use (address 0), the number of active cells.
// One request is worked at a time, with the cells read and written through
// the single-port-pair cell memory, one cell per cycle:
//   allocate   a scan for a free run of amount cells, then a fill of that run
//   erase      one scan of the M active cells
//   defragment a compaction pass over the M cells, then a tail clear
// where M is the active cell count. Each scan reads through the registered read port.
// After reset all MAX_CELLS cells of the memory are swept to zero;
// item_i.ready stays low meanwhile, APB writes are taken as usual.
// The result sits in an output register: a new request is taken while it
// waits, and a stalled receiver only holds the block when the next result
// is due.
module first_fit_cell_allocator_unit #(
  parameter int unsigned MAX_CELLS = 128,
  parameter int unsigned ID_BITS   = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  ffca_item_if.sink                            item_i,
  ffca_res_if.source                           result_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ffca_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [ffca_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [ffca_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import ffca_pkg::*;

  logic [CFG_W-1:0] cells_in_use_q;
  dp_ctrl_t         dp_ctrl;
  dp_stat_t         dp_stat;
  logic             reg_sel;

  // Register file: one register, word-aligned
  assign reg_sel = (paddr[2] == REG_CELLS_IN_USE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? APB_DATA_W'(cells_in_use_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_in_use_q <= CELLS_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      cells_in_use_q <= pwdata[CFG_W-1:0];
    end
  end

  ffca_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (item_i.valid),
    .in_action_i    (item_i.action),
    .in_ready_o     (item_i.ready),
    .out_ready_i    (result_o.ready),
    .out_valid_o    (result_o.valid),
    .out_status_o   (result_o.status),
    .out_alloc_id_o (result_o.alloc_id),
    .dp_ctrl_o      (dp_ctrl),
    .dp_stat_i      (dp_stat)
  );

  ffca_datapath #(
    .MAX_CELLS (MAX_CELLS),
    .ID_BITS   (ID_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (dp_ctrl),
    .cells_in_use_i (cells_in_use_q),
    .amount_i       (item_i.amount),
    .erase_id_i     (item_i.erase_id),
    .stat_o         (dp_stat)
  );

endmodule

>>> hdl/ffca_checker.sv
// Port-level checks of the allocator and their bind to the top level.
module ffca_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          item_valid_i,
  input logic                          item_ready_i,
  input logic [ffca_pkg::ACTION_W-1:0] item_action_i,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [ffca_pkg::STATUS_W-1:0] res_status_i,
  input logic [ffca_pkg::AID_W-1:0]    res_alloc_id_i
);
  import ffca_pkg::*;

  // A pending result beat stays until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result beat dropped before it was taken");

  // Failed or illegal results carry no identifier
  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_status_i != ST_OK) |-> (res_alloc_id_i == '0))
    else $error("non-zero identifier on a failed result");

  // A real request keeps the block busy for at least the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && item_ready_i && (item_action_i != ACT_UNUSED) |=> !item_ready_i)
    else $error("request taken while another is in progress");

  // Reset sweep: nothing is accepted in the first cycle after reset
  a_reset_busy: assert property (@(posedge clk_i)
    !rst_ni |=> !item_ready_i)
    else $error("request port ready during the reset sweep");

endmodule

bind first_fit_cell_allocator_unit ffca_checker u_ffca_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .item_valid_i   (item_i.valid),
  .item_ready_i   (item_i.ready),
  .item_action_i  (item_i.action),
  .res_valid_i    (result_o.valid),
  .res_ready_i    (result_o.ready),
  .res_status_i   (result_o.status),
  .res_alloc_id_i (result_o.alloc_id)
);

>>> bench/first_fit_cell_allocator_unit_tb.sv
// Self-checking bench for the first-fit cell allocator: directed, config, stall and random runs.
module first_fit_cell_allocator_unit_tb;
  import ffca_pkg::*;

  localparam int unsigned CELL_COUNT    = 128;
  localparam logic [AID_W-1:0] ID_LIMIT = 16'hFFFF;
  localparam logic REG_UNUSED = 1'b1;
  // worst request is a defragment of every cell: two passes plus overhead
  localparam int unsigned SETTLE_CYCLES = 2 * CELL_COUNT + 16;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [AMOUNT_W-1:0] amount;
    logic [EID_W-1:0]    erase_id;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [AID_W-1:0]    alloc_id;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;

  ffca_item_if item_bus ();
  ffca_res_if  res_bus ();

  first_fit_cell_allocator_unit #(
    .MAX_CELLS(CELL_COUNT),
    .ID_BITS  (16)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_bus),
    .result_o(res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the block: owner per cell, last identifier, active cell register
  logic [AID_W-1:0] cell_map [CELL_COUNT];
  logic [AID_W-1:0] issued_id;
  logic [CFG_W-1:0] cells_reg;

  res_t        due_results[$];
  int unsigned errors;
  int unsigned quiet_cycles;
  bit          src_idle;
  bit          sink_idle;
  int          sink_hold;

  function automatic int active_cells();
    return (cells_reg > CELL_COUNT) ? CELL_COUNT : cells_reg;
  endfunction

  // Random filler for fields that an action ignores
  function automatic logic [AMOUNT_W-1:0] rand_amount();
    return AMOUNT_W'($urandom);
  endfunction

  function automatic logic [EID_W-1:0] rand_eid();
    return EID_W'($urandom);
  endfunction

  // Applies one request to the shadow store; returns 1 when a result beat is due
  function automatic bit apply_to_cell_map(input req_t r, output res_t o);
    int m, amt, run, start, wr, i;
    bit found, has_result;
    m = active_cells();
    amt = r.amount;
    run = 0;
    start = 0;
    wr = 0;
    found = 1'b0;
    has_result = 1'b0;
    o.status = ST_FAIL;
    o.alloc_id = '0;
    case (r.action)
      ACT_ALLOC: begin
        has_result = 1'b1;
        if (amt != 0 && amt <= m && issued_id != ID_LIMIT) begin
          for (i = 0; i < m && !found; i++) begin
            run = (cell_map[i] == '0) ? run + 1 : 0;
            if (run == amt) begin
              found = 1'b1;
              start = i + 1 - amt;
            end
          end
        end
        if (found) begin
          issued_id = issued_id + 1'b1;
          for (i = start; i < start + amt; i++) cell_map[i] = issued_id;
          o.status = ST_OK;
          o.alloc_id = issued_id;
        end
      end
      ACT_ERASE: begin
        for (i = 0; i < m; i++) begin
          if (r.erase_id != '0 && cell_map[i] == r.erase_id) begin
            cell_map[i] = '0;
            found = 1'b1;
          end
        end
        if (!found) begin
          has_result = 1'b1;
          o.status = ST_ILLEGAL;
        end
      end
      ACT_DEFRAG: begin
        for (i = 0; i < m; i++) begin
          if (cell_map[i] != '0) begin
            cell_map[wr] = cell_map[i];
            wr++;
          end
        end
        for (i = wr; i < m; i++) cell_map[i] = '0;
      end
      default: has_result = 1'b0;
    endcase
    return has_result;
  endfunction

  function automatic req_t make_req(input logic [ACTION_W-1:0] action,
                                    input logic [AMOUNT_W-1:0] amount,
                                    input logic [EID_W-1:0] erase_id);
    req_t r;
    r.action = action;
    r.amount = amount;
    r.erase_id = erase_id;
    return r;
  endfunction

  // Some identifier that owns an active cell, or zero when the store is empty
  function automatic logic [AID_W-1:0] pick_owned();
    int m, start, k;
    m = active_cells();
    if (m == 0) return '0;
    start = $urandom_range(0, m - 1);
    for (k = 0; k < m; k++) begin
      if (cell_map[(start + k) % m] != '0) return cell_map[(start + k) % m];
    end
    return '0;
  endfunction

  // Mostly small allocates and erases of live owners; some noise
  function automatic req_t random_request();
    req_t r;
    int m, sel, pick;
    m = active_cells();
    sel = $urandom_range(0, 99);
    pick = $urandom_range(0, 19);
    r.amount = AMOUNT_W'($urandom_range(0, 255));
    r.erase_id = EID_W'($urandom_range(0, 65535));
    if (sel < 48) begin
      r.action = ACT_ALLOC;
      if (m != 0 && pick >= 3) r.amount = AMOUNT_W'($urandom_range(1, (m < 12) ? m : 12));
      else if (m != 0 && pick == 2) r.amount = AMOUNT_W'($urandom_range(1, m));
      else if (pick == 1) r.amount = '0;
    end else if (sel < 85) begin
      r.action = ACT_ERASE;
      if (pick < 15) r.erase_id = pick_owned();
      else if (pick < 17) r.erase_id = '0;
    end else if (sel < 96) begin
      r.action = ACT_DEFRAG;
    end else begin
      r.action = ACT_UNUSED;
    end
    return r;
  endfunction

  // Offers one request beat, optionally after an idle burst, and records its result
  task automatic send_request(input req_t r);
    res_t e;
    int gap;
    gap = 0;
    if (src_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      @(negedge clk_i);
      item_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    item_bus.valid    <= 1'b1;
    item_bus.action   <= r.action;
    item_bus.amount   <= r.amount;
    item_bus.erase_id <= r.erase_id;
    do @(posedge clk_i); while (item_bus.ready !== 1'b1);
    if (apply_to_cell_map(r, e)) due_results.push_back(e);
  endtask

  // Stops offering, waits for every due result, then lets a silent request finish
  task automatic wait_drained(input int unsigned extra);
    @(negedge clk_i);
    item_bus.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic idx, input logic [APB_DATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (idx == REG_CELLS_IN_USE) cells_reg = val[CFG_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_cells(input logic [CFG_W-1:0] val);
    wait_drained(SETTLE_CYCLES);
    apb_write(REG_CELLS_IN_USE, {{(APB_DATA_W - CFG_W){1'b0}}, val});
  endtask

  // Field extremes, each action and the named corner cases on the reset config
  task automatic test_directed_cases();
    logic [AID_W-1:0] id_a, id_b;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    send_request(make_req(ACT_ALLOC, 8'd1, rand_eid()));
    id_a = issued_id;
    send_request(make_req(ACT_ALLOC, 8'd0, rand_eid()));
    send_request(make_req(ACT_ALLOC, 8'd128, rand_eid()));
    send_request(make_req(ACT_ALLOC, 8'd255, rand_eid()));
    send_request(make_req(ACT_ALLOC, 8'd127, rand_eid()));
    id_b = issued_id;
    // store is full now
    send_request(make_req(ACT_ALLOC, 8'd1, rand_eid()));
    send_request(make_req(ACT_ERASE, rand_amount(), 16'h0000));
    send_request(make_req(ACT_ERASE, rand_amount(), 16'hFFFF));
    send_request(make_req(ACT_ERASE, rand_amount(), id_a));
    send_request(make_req(ACT_UNUSED, rand_amount(), rand_eid()));
    send_request(make_req(ACT_ALLOC, 8'd2, rand_eid()));
    send_request(make_req(ACT_ALLOC, 8'd1, rand_eid()));
    id_a = issued_id;
    send_request(make_req(ACT_ERASE, rand_amount(), id_b));
    send_request(make_req(ACT_ALLOC, 8'd5, rand_eid()));
    id_b = issued_id;
    // hole at cell zero, then compaction slides the run down
    send_request(make_req(ACT_ERASE, rand_amount(), id_a));
    send_request(make_req(ACT_DEFRAG, rand_amount(), rand_eid()));
    send_request(make_req(ACT_ALLOC, 8'd123, rand_eid()));
    id_a = issued_id;
    send_request(make_req(ACT_ERASE, rand_amount(), id_b));
    send_request(make_req(ACT_ERASE, rand_amount(), id_a));
    send_request(make_req(ACT_ALLOC, 8'd128, rand_eid()));
    send_request(make_req(ACT_ERASE, rand_amount(), issued_id));
    send_request(make_req(ACT_DEFRAG, rand_amount(), rand_eid()));
  endtask

  // Active cell count at zero, one, mid, above the store, and a write to no register
  task automatic test_cells_in_use();
    logic [AID_W-1:0] id_a;
    set_cells(8'd128);
    send_request(make_req(ACT_ALLOC, 8'd10, rand_eid()));
    id_a = issued_id;
    set_cells(8'd4);
    send_request(make_req(ACT_ERASE, rand_amount(), id_a));
    send_request(make_req(ACT_ALLOC, 8'd4, rand_eid()));
    send_request(make_req(ACT_ALLOC, 8'd1, rand_eid()));
    send_request(make_req(ACT_ALLOC, 8'd5, rand_eid()));
    send_request(make_req(ACT_DEFRAG, rand_amount(), rand_eid()));
    set_cells(8'd0);
    send_request(make_req(ACT_ALLOC, 8'd1, rand_eid()));
    send_request(make_req(ACT_ERASE, rand_amount(), id_a));
    send_request(make_req(ACT_DEFRAG, rand_amount(), rand_eid()));
    set_cells(8'd200);
    // the upper part of the old run is still there
    send_request(make_req(ACT_ERASE, rand_amount(), id_a));
    send_request(make_req(ACT_ALLOC, 8'd128, rand_eid()));
    send_request(make_req(ACT_DEFRAG, rand_amount(), rand_eid()));
    set_cells(8'd255);
    send_request(make_req(ACT_ALLOC, 8'd124, rand_eid()));
    wait_drained(SETTLE_CYCLES);
    apb_write(REG_UNUSED, 32'h0000_0005);
    send_request(make_req(ACT_ALLOC, 8'd1, rand_eid()));
    set_cells(8'd1);
    send_request(make_req(ACT_ERASE, rand_amount(), cell_map[0]));
    send_request(make_req(ACT_ALLOC, 8'd1, rand_eid()));
    send_request(make_req(ACT_ALLOC, 8'd1, rand_eid()));
  endtask

  // Receiver holds off long enough that the result register and the request side fill
  task automatic test_backpressure();
    int k;
    set_cells(8'd128);
    sink_hold = HOLD_CYCLES;
    for (k = 0; k < 8; k++) begin
      send_request(make_req(ACT_ALLOC, AMOUNT_W'($urandom_range(1, 4)), rand_eid()));
    end
    send_request(make_req(ACT_ERASE, rand_amount(), 16'h0000));
    send_request(make_req(ACT_ERASE, rand_amount(), pick_owned()));
    wait_drained(0);
  endtask

  task automatic test_random_traffic();
    int chunk, k;
    logic [CFG_W-1:0] val;
    for (chunk = 0; chunk < 8; chunk++) begin
      case (chunk)
        1: val = CFG_W'($urandom_range(1, 128));
        2: val = 8'd33;
        3: val = 8'd255;
        4: val = 8'd8;
        6: val = CFG_W'($urandom_range(64, 128));
        default: val = 8'd128;
      endcase
      set_cells(val);
      // late chunks run without idling
      src_idle  = (chunk < 6) && (chunk != 2);
      sink_idle = (chunk < 6) && (chunk != 3);
      for (k = 0; k < 40; k++) begin
        if (k == 20 && chunk[0]) wait_drained(0);
        send_request(random_request());
      end
    end
  endtask

  // One active cell, allocate and erase in turn, then widen the store again
  task automatic test_single_cell_churn();
    int k;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    set_cells(8'd1);
    for (k = 0; k < 16; k++) begin
      if (cell_map[0] == '0) send_request(make_req(ACT_ALLOC, 8'd1, rand_eid()));
      else send_request(make_req(ACT_ERASE, rand_amount(), cell_map[0]));
    end
    send_request(make_req(ACT_ERASE, rand_amount(), ID_LIMIT));
    send_request(make_req(ACT_ALLOC, 8'd1, rand_eid()));
    send_request(make_req(ACT_ALLOC, 8'd0, rand_eid()));
    set_cells(8'd128);
    send_request(make_req(ACT_ALLOC, 8'd1, rand_eid()));
    send_request(make_req(ACT_DEFRAG, rand_amount(), rand_eid()));
    for (k = 0; k < 10; k++) begin
      send_request(make_req(ACT_ERASE, rand_amount(), pick_owned()));
    end
    send_request(make_req(ACT_ALLOC, 8'd2, rand_eid()));
  endtask

  // Receiver: long hold-off when asked, else random stall bursts
  initial begin : result_sink
    int burst;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        res_bus.ready <= 1'b0;
        sink_hold--;
      end else if (burst > 0) begin
        res_bus.ready <= 1'b0;
        burst--;
      end else begin
        res_bus.ready <= 1'b1;
        if (sink_idle && $urandom_range(0, 7) == 0) burst = $urandom_range(1, 14);
      end
    end
  end

  // Compare each result beat with the oldest due result
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      if (due_results.size() == 0) begin
        $error("unexpected result beat: status %0d alloc_id %0d",
               res_bus.status, res_bus.alloc_id);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (res_bus.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, res_bus.status);
          errors++;
        end
        if (res_bus.alloc_id !== want.alloc_id) begin
          $error("alloc_id: expected %0d, actual %0d", want.alloc_id, res_bus.alloc_id);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
        (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    item_bus.valid = 1'b0;
    item_bus.action = ACT_ALLOC;
    item_bus.amount = '0;
    item_bus.erase_id = '0;
    res_bus.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    quiet_cycles = 0;
    sink_hold = 0;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    foreach (cell_map[i]) cell_map[i] = '0;
    issued_id = '0;
    cells_reg = CELLS_RESET;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_cells_in_use();
    test_backpressure();
    test_random_traffic();
    test_single_cell_churn();
    wait_drained(SETTLE_CYCLES);

    if (errors == 0 && due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
